// ===== src/sbb_pkg.sv =====
package sbb_pkg;

  localparam int MAX_WIDTH   = 4096;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MAX_RADIUS  = 15;
  localparam int HLINES      = 32;   // ring of line stores, power of two

  localparam int PIX_W       = 16;
  localparam int DIM_W       = 13;   // holds 1..4096
  localparam int COL_W       = 12;   // column / row index
  localparam int ROW_W       = 13;   // input row, counts past the image while draining
  localparam int LINE_W      = 5;    // log2(HLINES)
  localparam int RAD_W       = 4;
  localparam int TAP_W       = 5;    // 0..2r
  localparam int SUM_W       = 21;   // 31 * 65535 < 2**21
  localparam int RECIP_W     = 27;
  localparam int RECIP_SHIFT = 26;
  localparam int PROD_W      = SUM_W + RECIP_W;
  localparam int LEAD_W      = 17;   // r*W + r + 1
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int MASK_W      = 3;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_RADIUS = 2'd2,
    REG_MASK   = 2'd3
  } reg_idx_e;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } mode_e;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_READ  = 7'b0000010,
    ST_DRAIN = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_HWR   = 7'b0010000,
    ST_ADV   = 7'b0100000,
    ST_EMIT  = 7'b1000000
  } state_e;

  typedef logic [2:0][PIX_W-1:0] pix_t;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [RAD_W-1:0]  rad;
    logic [LEAD_W-1:0] delay;
    logic [MASK_W-1:0] mask;
  } geom_t;

  // floor(2**26 / (2r+1)) + 1: exact quotient for sums below 2**21
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] rad);
    logic [RECIP_W-1:0] m;
    unique case (rad)
      4'd0:    m = 27'd67108865;
      4'd1:    m = 27'd22369622;
      4'd2:    m = 27'd13421773;
      4'd3:    m = 27'd9586981;
      4'd4:    m = 27'd7456541;
      4'd5:    m = 27'd6100806;
      4'd6:    m = 27'd5162221;
      4'd7:    m = 27'd4473925;
      4'd8:    m = 27'd3947581;
      4'd9:    m = 27'd3532046;
      4'd10:   m = 27'd3195661;
      4'd11:   m = 27'd2917777;
      4'd12:   m = 27'd2684355;
      4'd13:   m = 27'd2485514;
      4'd14:   m = 27'd2314099;
      default: m = 27'd2164803;
    endcase
    return m;
  endfunction

endpackage

// ===== src/sbb_in_if.sv =====
interface sbb_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [sbb_pkg::PIX_W-1:0] chan_a;
  logic [sbb_pkg::PIX_W-1:0] chan_b;
  logic [sbb_pkg::PIX_W-1:0] chan_c;

  modport source (output valid, mode, chan_a, chan_b, chan_c, input ready);
  modport sink   (input valid, mode, chan_a, chan_b, chan_c, output ready);
endinterface

// ===== src/sbb_out_if.sv =====
interface sbb_out_if;
  logic                      valid;
  logic                      ready;
  logic [sbb_pkg::PIX_W-1:0] out_a;
  logic [sbb_pkg::PIX_W-1:0] out_b;
  logic [sbb_pkg::PIX_W-1:0] out_c;
  logic                      frame_last;

  modport source (output valid, out_a, out_b, out_c, frame_last, input ready);
  modport sink   (input valid, out_a, out_b, out_c, frame_last, output ready);
endinterface

// ===== src/sbb_div.sv =====
// Divide by 2r+1 through a reciprocal multiply; the product is registered.
module sbb_div (
  input  logic                        clk_i,
  input  logic [sbb_pkg::SUM_W-1:0]   sum_i,
  input  logic [sbb_pkg::RAD_W-1:0]   rad_i,
  output logic [sbb_pkg::PIX_W-1:0]   quo_o
);

  logic [sbb_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= sbb_pkg::PROD_W'(sum_i) * sbb_pkg::PROD_W'(sbb_pkg::recip(rad_i));
  end

  assign quo_o = prod_q[sbb_pkg::RECIP_SHIFT +: sbb_pkg::PIX_W];

endmodule

// ===== src/sbb_core.sv =====
module sbb_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sbb_pkg::geom_t       geom_i,
  input  logic                 restart_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 in_mode_i,
  input  sbb_pkg::pix_t        in_pix_i,
  output logic                 res_valid_o,
  input  logic                 res_take_i,
  output sbb_pkg::pix_t        res_pix_o,
  output logic                 res_last_o
);

  localparam int HL_AW = sbb_pkg::LINE_W + sbb_pkg::COL_W;

  sbb_pkg::pix_t raw_mem [sbb_pkg::MAX_WIDTH];
  sbb_pkg::pix_t hl_mem  [sbb_pkg::HLINES * sbb_pkg::MAX_WIDTH];

  sbb_pkg::state_e state_q, state_d;

  logic [sbb_pkg::COL_W-1:0]  in_col_q, in_col_d;
  logic [sbb_pkg::ROW_W-1:0]  in_row_q, in_row_d;
  logic [sbb_pkg::COL_W-1:0]  ox_q, ox_d, oy_q, oy_d;
  logic [sbb_pkg::LEAD_W-1:0] lead_q, lead_d;
  logic [sbb_pkg::COL_W-1:0]  x_q, x_d, xend_q, xend_d;
  logic [sbb_pkg::TAP_W-1:0]  k_q, k_d, rtap_q;
  logic [1:0]                 ch_q, ch_d;
  logic                       vert_q, vert_d, rdv_q;

  logic [2:0][sbb_pkg::SUM_W-1:0] sum_q;
  sbb_pkg::pix_t ctr_q, avg_q, raw_rd_q, hl_rd_q, rd_data, blend;

  logic [sbb_pkg::COL_W-1:0]  wm1, hm1, base, lim, tap, col_minus_r;
  logic [sbb_pkg::TAP_W-1:0]  last_tap;
  logic signed [14:0]         pos;
  logic                       raw_we, hl_we, row_in_image, col_ge_r, col_last, out_last;
  logic [HL_AW-1:0]           hl_ra, hl_wa;
  logic [sbb_pkg::SUM_W-1:0]  div_in;
  logic [sbb_pkg::PIX_W-1:0]  quo;

  assign wm1          = sbb_pkg::COL_W'(geom_i.width - 13'd1);
  assign hm1          = sbb_pkg::COL_W'(geom_i.height - 13'd1);
  assign last_tap     = {geom_i.rad, 1'b0};
  assign row_in_image = in_row_q < geom_i.height;
  assign col_ge_r     = in_col_q >= sbb_pkg::COL_W'(geom_i.rad);
  assign col_last     = in_col_q == wm1;
  assign col_minus_r  = in_col_q - sbb_pkg::COL_W'(geom_i.rad);
  assign out_last     = (oy_q == hm1) && (ox_q == wm1);

  // clamped tap position: replicate edge pixel / edge row
  assign base = vert_q ? oy_q : x_q;
  assign lim  = vert_q ? hm1 : wm1;
  assign pos  = $signed({3'b000, base}) + $signed({10'd0, k_q})
              - $signed({11'd0, geom_i.rad});

  always_comb begin
    priority if (pos < 15'sd0) begin
      tap = '0;
    end else if (pos > $signed({3'b000, lim})) begin
      tap = lim;
    end else begin
      tap = pos[sbb_pkg::COL_W-1:0];
    end
  end

  assign hl_ra   = {tap[sbb_pkg::LINE_W-1:0], ox_q};
  assign hl_wa   = {in_row_q[sbb_pkg::LINE_W-1:0], x_q};
  assign rd_data = vert_q ? hl_rd_q : raw_rd_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      blend[c] = geom_i.mask[c] ? avg_q[c] : ctr_q[c];
    end
  end

  always_comb begin
    unique case (ch_q)
      2'd1:    div_in = sum_q[1];
      2'd2:    div_in = sum_q[2];
      default: div_in = sum_q[0];
    endcase
  end

  sbb_div u_div (
    .clk_i (clk_i),
    .sum_i (div_in),
    .rad_i (geom_i.rad),
    .quo_o (quo)
  );

  always_comb begin
    state_d     = state_q;
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    ox_d        = ox_q;
    oy_d        = oy_q;
    lead_d      = lead_q;
    x_d         = x_q;
    xend_d      = xend_q;
    k_d         = k_q;
    ch_d        = ch_q;
    vert_d      = vert_q;
    raw_we      = 1'b0;
    hl_we       = 1'b0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      sbb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!row_in_image) begin
            state_d = sbb_pkg::ST_ADV;          // drain tick
          end else if (in_mode_i == sbb_pkg::MODE_PIXEL) begin
            raw_we = 1'b1;
            if (col_ge_r || col_last) begin
              x_d     = col_ge_r ? col_minus_r : '0;
              xend_d  = col_last ? wm1 : col_minus_r;
              k_d     = '0;
              vert_d  = 1'b0;
              state_d = sbb_pkg::ST_READ;
            end else begin
              state_d = sbb_pkg::ST_ADV;
            end
          end
        end
      end
      sbb_pkg::ST_READ: begin
        if (k_q == last_tap) begin
          state_d = sbb_pkg::ST_DRAIN;
        end else begin
          k_d = k_q + 5'd1;
        end
      end
      sbb_pkg::ST_DRAIN: begin
        ch_d    = '0;
        state_d = sbb_pkg::ST_DIV;
      end
      sbb_pkg::ST_DIV: begin
        if (ch_q == 2'd3) begin
          state_d = vert_q ? sbb_pkg::ST_EMIT : sbb_pkg::ST_HWR;
        end else begin
          ch_d = ch_q + 2'd1;
        end
      end
      sbb_pkg::ST_HWR: begin
        hl_we = 1'b1;
        if (x_q == xend_q) begin
          state_d = sbb_pkg::ST_ADV;
        end else begin
          x_d     = x_q + 12'd1;
          k_d     = '0;
          state_d = sbb_pkg::ST_READ;
        end
      end
      sbb_pkg::ST_ADV: begin
        if (in_col_q == wm1) begin
          in_col_d = '0;
          in_row_d = in_row_q + 13'd1;
        end else begin
          in_col_d = in_col_q + 12'd1;
        end
        if (lead_q >= geom_i.delay) begin
          vert_d  = 1'b1;
          k_d     = '0;
          state_d = sbb_pkg::ST_READ;
        end else begin
          lead_d  = lead_q + 17'd1;
          state_d = sbb_pkg::ST_IDLE;
        end
      end
      sbb_pkg::ST_EMIT: begin
        res_valid_o = 1'b1;
        if (res_take_i) begin
          if (out_last) begin
            in_col_d = '0;
            in_row_d = '0;
            ox_d     = '0;
            oy_d     = '0;
            lead_d   = '0;
          end else if (ox_q == wm1) begin
            ox_d = '0;
            oy_d = oy_q + 12'd1;
          end else begin
            ox_d = ox_q + 12'd1;
          end
          state_d = sbb_pkg::ST_IDLE;
        end
      end
      default: state_d = sbb_pkg::ST_IDLE;
    endcase
    if (restart_i) begin
      in_col_d = '0;
      in_row_d = '0;
      ox_d     = '0;
      oy_d     = '0;
      lead_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sbb_pkg::ST_IDLE;
      in_col_q <= '0;
      in_row_q <= '0;
      ox_q     <= '0;
      oy_q     <= '0;
      lead_q   <= '0;
      k_q      <= '0;
      ch_q     <= '0;
      vert_q   <= 1'b0;
      rdv_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_col_q <= in_col_d;
      in_row_q <= in_row_d;
      ox_q     <= ox_d;
      oy_q     <= oy_d;
      lead_q   <= lead_d;
      k_q      <= k_d;
      ch_q     <= ch_d;
      vert_q   <= vert_d;
      rdv_q    <= state_q == sbb_pkg::ST_READ;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    xend_q <= xend_d;
    rtap_q <= k_q;
    if (rdv_q) begin
      for (int c = 0; c < 3; c++) begin
        sum_q[c] <= ((rtap_q == '0) ? '0 : sum_q[c]) + sbb_pkg::SUM_W'(rd_data[c]);
      end
      if (rtap_q == sbb_pkg::TAP_W'(geom_i.rad)) begin
        ctr_q <= rd_data;
      end
    end
    if (state_q == sbb_pkg::ST_DIV && ch_q != 2'd0) begin
      avg_q[ch_q - 2'd1] <= quo;
    end
  end

  // line memories, registered read
  always_ff @(posedge clk_i) begin
    if (raw_we) begin
      raw_mem[in_col_q] <= in_pix_i;
    end
    raw_rd_q <= raw_mem[tap];
  end

  always_ff @(posedge clk_i) begin
    if (hl_we) begin
      hl_mem[hl_wa] <= blend;
    end
    hl_rd_q <= hl_mem[hl_ra];
  end

  assign res_pix_o  = blend;
  assign res_last_o = out_last;

endmodule

// ===== src/separable_box_blur.sv =====
// Separable box blur with edge replication over a raster pixel stream.
// pix_i carries one transaction per pixel: mode selects a new pixel or a
// flush tick, chan_a..chan_c are the three 16-bit samples. pix_o carries
// the blurred pixels in raster order; frame_last marks the frame's final
// pixel. Output trails input by r rows plus r pixels, so after a frame's
// last pixel the source sends flush ticks until frame_last appears.
// A flush tick sent while the frame still expects pixels is dropped.
// Pixels are processed one at a time: a new transaction is taken only once
// the last one is through. A horizontal average is made for each pixel from
// column r on, and a vertical one when a transaction produces an output; at
// the end of each row r further horizontal averages follow. Each average
// reads the line memory once per tap, then a shared reciprocal divider takes
// the three channels in turn.
// Registers on the APB port: 0 image_width, 1 image_height, 2 blur_radius,
// 3 channel_mask. Writing any geometry register restarts the frame.
// Reset restores the register defaults and zeroes the frame counters; the
// line memories are not cleared (no clearing pass).
// A stalled receiver is absorbed by the output register: the next pixel is
// still taken and worked on until its result has to be handed over.
module separable_box_blur (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  sbb_in_if.sink                       pix_i,
  sbb_out_if.source                    pix_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [sbb_pkg::ADDR_W-1:0]   paddr,
  input  logic [sbb_pkg::DATA_W-1:0]   pwdata,
  output logic [sbb_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [sbb_pkg::DIM_W-1:0]  cfg_w_q, cfg_h_q, w_eff, h_eff;
  logic [sbb_pkg::RAD_W-1:0]  cfg_r_q;
  logic [sbb_pkg::MASK_W-1:0] cfg_m_q;
  sbb_pkg::geom_t             geom_q, geom_d;
  sbb_pkg::reg_idx_e          idx;
  logic                       wr, restart;

  // result side
  logic          res_valid, res_take, res_last, oval_q, olast_q;
  sbb_pkg::pix_t res_pix, opix_q;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign idx     = sbb_pkg::reg_idx_e'(paddr[3:2]);
  assign restart = wr && (idx != sbb_pkg::REG_MASK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= 13'd640;
      cfg_h_q <= 13'd480;
      cfg_r_q <= 4'd1;
      cfg_m_q <= 3'd7;
    end else if (wr) begin
      unique case (idx)
        sbb_pkg::REG_WIDTH:  cfg_w_q <= pwdata[sbb_pkg::DIM_W-1:0];
        sbb_pkg::REG_HEIGHT: cfg_h_q <= pwdata[sbb_pkg::DIM_W-1:0];
        sbb_pkg::REG_RADIUS: cfg_r_q <= pwdata[sbb_pkg::RAD_W-1:0];
        sbb_pkg::REG_MASK:   cfg_m_q <= pwdata[sbb_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      sbb_pkg::REG_WIDTH:  prdata = sbb_pkg::DATA_W'(cfg_w_q);
      sbb_pkg::REG_HEIGHT: prdata = sbb_pkg::DATA_W'(cfg_h_q);
      sbb_pkg::REG_RADIUS: prdata = sbb_pkg::DATA_W'(cfg_r_q);
      sbb_pkg::REG_MASK:   prdata = sbb_pkg::DATA_W'(cfg_m_q);
      default:             prdata = '0;
    endcase
  end

  // clamp geometry into range, precompute the r*W + r lag
  always_comb begin
    priority if (cfg_w_q == '0) begin
      w_eff = 13'd1;
    end else if (cfg_w_q > sbb_pkg::DIM_W'(sbb_pkg::MAX_WIDTH)) begin
      w_eff = sbb_pkg::DIM_W'(sbb_pkg::MAX_WIDTH);
    end else begin
      w_eff = cfg_w_q;
    end
    priority if (cfg_h_q == '0) begin
      h_eff = 13'd1;
    end else if (cfg_h_q > sbb_pkg::DIM_W'(sbb_pkg::MAX_HEIGHT)) begin
      h_eff = sbb_pkg::DIM_W'(sbb_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg_h_q;
    end
    geom_d.width  = w_eff;
    geom_d.height = h_eff;
    geom_d.rad    = cfg_r_q;
    geom_d.delay  = sbb_pkg::LEAD_W'(cfg_r_q) * sbb_pkg::LEAD_W'(w_eff)
                  + sbb_pkg::LEAD_W'(cfg_r_q);
    geom_d.mask   = cfg_m_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      geom_q <= '{width: 13'd640, height: 13'd480, rad: 4'd1,
                  delay: 17'd641, mask: 3'd7};
    end else begin
      geom_q <= geom_d;
    end
  end

  sbb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom_q),
    .restart_i   (restart),
    .in_valid_i  (pix_i.valid),
    .in_ready_o  (pix_i.ready),
    .in_mode_i   (pix_i.mode),
    .in_pix_i    ({pix_i.chan_c, pix_i.chan_b, pix_i.chan_a}),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_pix_o   (res_pix),
    .res_last_o  (res_last)
  );

  // output register: loads when empty or being drained this cycle
  assign res_take = res_valid && (!oval_q || pix_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oval_q <= 1'b0;
    end else if (res_take) begin
      oval_q <= 1'b1;
    end else if (pix_o.ready) begin
      oval_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      opix_q  <= res_pix;
      olast_q <= res_last;
    end
  end

  assign pix_o.valid      = oval_q;
  assign pix_o.out_a      = opix_q[0];
  assign pix_o.out_b      = opix_q[1];
  assign pix_o.out_c      = opix_q[2];
  assign pix_o.frame_last = olast_q;

endmodule

// ===== src/sbb_checker.sv =====
module sbb_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [sbb_pkg::PIX_W-1:0]  out_a_i,
  input logic [sbb_pkg::PIX_W-1:0]  out_b_i,
  input logic [sbb_pkg::PIX_W-1:0]  out_c_i,
  input logic                       frame_last_i,
  input logic                       pready_i
);

  logic [31:0] bal_q;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // accepted input transactions minus delivered results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bal_q <= '0;
    end else begin
      bal_q <= bal_q + 32'(in_acc) - 32'(out_acc);
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_a_i)
      && $stable(out_b_i) && $stable(out_c_i) && $stable(frame_last_i))
    else $error("result changed while stalled");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> bal_q != '0)
    else $error("result without a preceding input transaction");

  a_first_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("result shown straight out of reset");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_i)
    else $error("config port wait state");

endmodule

bind separable_box_blur sbb_checker u_sbb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (pix_i.valid),
  .in_ready_i   (pix_i.ready),
  .out_valid_i  (pix_o.valid),
  .out_ready_i  (pix_o.ready),
  .out_a_i      (pix_o.out_a),
  .out_b_i      (pix_o.out_b),
  .out_c_i      (pix_o.out_c),
  .frame_last_i (pix_o.frame_last),
  .pready_i     (pready)
);
